FILE: src/utrb_pkg.sv
// shared constants and types for the uart ring buffer pair
package utrb_pkg;

  localparam int unsigned SEND_DEPTH = 16;
  localparam int unsigned RECV_DEPTH = 16;

  localparam int unsigned SEND_AW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam int unsigned RECV_AW = (RECV_DEPTH > 1) ? $clog2(RECV_DEPTH) : 1;

  localparam int unsigned BYTE_W = 8;

  typedef logic [SEND_AW-1:0] send_ptr_t;
  typedef logic [RECV_AW-1:0] recv_ptr_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  typedef enum logic [1:0] {
    CMD_RX_BYTE    = 2'd0,
    CMD_HOST_READ  = 2'd1,
    CMD_HOST_WRITE = 2'd2,
    CMD_TX_READY   = 2'd3
  } cmd_e;

endpackage

FILE: src/uart_tx_rx_ring_buffers.sv
// uart transmit and receive ring queues sharing one command port
//
//  channel   | handshake            | beat fields
//  ----------+----------------------+---------------------------------------------
//  command   | start_i / busy_o     | cmd_i, byte_value_i, parity_error_i
//  result    | done_o (strobe)      | read_data_o, read_valid_o, tx_byte_o,
//            |                      | tx_valid_o, write_accepted_o, rx_dropped_o
//
// one command per clock; its result is strobed on done_o in the following cycle.
// pointers and flags update at the accepting edge; the byte popped from either
// queue comes from the synchronous queue memory, read at that edge, with the result.
// busy_o stays low, so commands may be issued every cycle.
// reset clears pointers and marks the transmitter free; queue memories are not cleared.
// the receiver of results cannot stall; each result is present for one cycle only.
module uart_tx_rx_ring_buffers (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] byte_value_i,
  input  logic       parity_error_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       read_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic       write_accepted_o,
  output logic       rx_dropped_o
);

  utrb_pkg::byte_t send_mem [utrb_pkg::SEND_DEPTH];
  utrb_pkg::byte_t recv_mem [utrb_pkg::RECV_DEPTH];

  utrb_pkg::send_ptr_t send_head_q, send_head_d, send_tail_q, send_tail_d;
  utrb_pkg::recv_ptr_t recv_head_q, recv_head_d, recv_tail_q, recv_tail_d;
  utrb_pkg::send_ptr_t send_head_nxt, send_tail_nxt;
  utrb_pkg::recv_ptr_t recv_head_nxt, recv_tail_nxt;
  logic tx_free_q, tx_free_d;

  logic done_q, rv_q, txv_q, tx_mem_q, acc_q, drop_q;
  logic rv_d, txv_d, tx_mem_d, acc_d, drop_d;
  utrb_pkg::byte_t byte_q;
  utrb_pkg::byte_t send_rdata_q, recv_rdata_q;

  logic accept;
  logic send_push, send_pop, recv_push, recv_pop;
  logic send_empty, recv_empty;
  utrb_pkg::cmd_e cmd;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign cmd    = utrb_pkg::cmd_e'(cmd_i);

  assign send_head_nxt = (send_head_q == utrb_pkg::send_ptr_t'(utrb_pkg::SEND_DEPTH - 1)) ?
                         '0 : send_head_q + 1'b1;
  assign send_tail_nxt = (send_tail_q == utrb_pkg::send_ptr_t'(utrb_pkg::SEND_DEPTH - 1)) ?
                         '0 : send_tail_q + 1'b1;
  assign recv_head_nxt = (recv_head_q == utrb_pkg::recv_ptr_t'(utrb_pkg::RECV_DEPTH - 1)) ?
                         '0 : recv_head_q + 1'b1;
  assign recv_tail_nxt = (recv_tail_q == utrb_pkg::recv_ptr_t'(utrb_pkg::RECV_DEPTH - 1)) ?
                         '0 : recv_tail_q + 1'b1;

  assign send_empty = (send_head_q == send_tail_q);
  assign recv_empty = (recv_head_q == recv_tail_q);

  always_comb begin
    send_push = 1'b0;
    send_pop  = 1'b0;
    recv_push = 1'b0;
    recv_pop  = 1'b0;
    rv_d      = 1'b0;
    txv_d     = 1'b0;
    tx_mem_d  = 1'b0;
    acc_d     = 1'b0;
    drop_d    = 1'b0;
    tx_free_d = tx_free_q;
    if (accept) begin
      unique case (cmd)
        utrb_pkg::CMD_RX_BYTE: begin
          if (parity_error_i || (recv_head_nxt == recv_tail_q)) begin
            drop_d = 1'b1;
          end else begin
            recv_push = 1'b1;
          end
        end
        utrb_pkg::CMD_HOST_READ: begin
          if (!recv_empty) begin
            recv_pop = 1'b1;
            rv_d     = 1'b1;
          end
        end
        utrb_pkg::CMD_HOST_WRITE: begin
          if (send_empty && tx_free_q) begin
            txv_d     = 1'b1;
            acc_d     = 1'b1;
            tx_free_d = 1'b0;
          end else if (send_head_nxt != send_tail_q) begin
            send_push = 1'b1;
            acc_d     = 1'b1;
          end
        end
        utrb_pkg::CMD_TX_READY: begin
          if (!send_empty) begin
            send_pop  = 1'b1;
            txv_d     = 1'b1;
            tx_mem_d  = 1'b1;
            tx_free_d = 1'b0;
          end else begin
            tx_free_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign send_head_d = send_push ? send_head_nxt : send_head_q;
  assign send_tail_d = send_pop  ? send_tail_nxt : send_tail_q;
  assign recv_head_d = recv_push ? recv_head_nxt : recv_head_q;
  assign recv_tail_d = recv_pop  ? recv_tail_nxt : recv_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_head_q <= '0;
      send_tail_q <= '0;
      recv_head_q <= '0;
      recv_tail_q <= '0;
      tx_free_q   <= 1'b1;
      done_q      <= 1'b0;
      rv_q        <= 1'b0;
      txv_q       <= 1'b0;
      tx_mem_q    <= 1'b0;
      acc_q       <= 1'b0;
      drop_q      <= 1'b0;
    end else begin
      send_head_q <= send_head_d;
      send_tail_q <= send_tail_d;
      recv_head_q <= recv_head_d;
      recv_tail_q <= recv_tail_d;
      tx_free_q   <= tx_free_d;
      done_q      <= accept;
      rv_q        <= rv_d;
      txv_q       <= txv_d;
      tx_mem_q    <= tx_mem_d;
      acc_q       <= acc_d;
      drop_q      <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_value_i;
    end
  end

  // queue memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (send_push) begin
      send_mem[send_head_q] <= byte_value_i;
    end
    if (send_pop) begin
      send_rdata_q <= send_mem[send_tail_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (recv_push) begin
      recv_mem[recv_head_q] <= byte_value_i;
    end
    if (recv_pop) begin
      recv_rdata_q <= recv_mem[recv_tail_q];
    end
  end

  assign done_o           = done_q;
  assign read_valid_o     = rv_q;
  assign read_data_o      = rv_q ? recv_rdata_q : '0;
  assign tx_valid_o       = txv_q;
  assign tx_byte_o        = !txv_q ? '0 : (tx_mem_q ? send_rdata_q : byte_q);
  assign write_accepted_o = acc_q;
  assign rx_dropped_o     = drop_q;

  a_done_follows_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result strobe without a command beat");

  a_flags_with_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_valid_o || tx_valid_o || write_accepted_o || rx_dropped_o) |-> done_o)
    else $error("result flag outside a result beat");

  a_one_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({read_valid_o, tx_valid_o || write_accepted_o, rx_dropped_o}) <= 1)
    else $error("result mixes outcomes of different commands");

  a_tx_busy_after_send : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o |-> !tx_free_q)
    else $error("transmitter marked free after a byte was handed over");

endmodule
